>>> hw/rtl/frame_rate_decimator_assert.svh
`ifndef FRAME_RATE_DECIMATOR_ASSERT_SVH
`define FRAME_RATE_DECIMATOR_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define FRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame rate decimator check failed");

// next-cycle implication, checked while out of reset
`define FRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame rate decimator check failed");

`endif

>>> hw/rtl/frd_pkg.sv
`timescale 1ns / 1ps
package frd_pkg;

    localparam int TIME_BITS      = 48;
    localparam int COUNT_BITS     = 32;
    localparam int CFG_BITS       = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam int INDEX_BITS     = 34;
    // frame_number * scale + divisor/2 fits in this many bits
    localparam int NUM_BITS       = COUNT_BITS + CFG_BITS + 1;
    localparam int STEP_BITS      = $clog2(NUM_BITS + 1);

    localparam logic [CFG_BITS-1:0]   INDEX_SCALE   = CFG_BITS'(10000000);
    localparam logic [CFG_BITS-1:0]   DIVISOR_RESET = CFG_BITS'(10000000);
    localparam logic [CFG_BITS-1:0]   PERIOD_RESET  = CFG_BITS'(333333);
    localparam logic [INDEX_BITS:0]   INDEX_WINDOW  = (INDEX_BITS+1)'(10);
    localparam logic [INDEX_BITS-1:0] INDEX_MAX     = {1'b0, {(INDEX_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_DIVISOR = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_LIMIT = 1'b1;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] numerator;
        logic [CFG_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NUM_BITS-1:0] quotient;
    } t_div_rsp;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
    endfunction

endpackage

>>> hw/rtl/frd_div.sv
`timescale 1ns / 1ps
`include "frame_rate_decimator_assert.svh"
module frd_div
    import frd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // restoring divide, one quotient bit a cycle
    logic [CFG_BITS:0]    r_rem, n_rem;
    logic [NUM_BITS-1:0]  r_quo, n_quo;
    logic [CFG_BITS-1:0]  r_den;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CFG_BITS:0]    w_shift;

    always_comb begin
        w_shift = {r_rem[CFG_BITS-1:0], r_quo[NUM_BITS-1]};
        if (w_shift >= {1'b0, r_den}) begin
            n_rem = w_shift - {1'b0, r_den};
            n_quo = {r_quo[NUM_BITS-2:0], 1'b1};
        end else begin
            n_rem = w_shift;
            n_quo = {r_quo[NUM_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.numerator;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `FRD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
    `FRD_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `FRD_ASSERT_NOW(a_busy_count, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

>>> hw/rtl/frame_rate_decimator.sv
`timescale 1ns / 1ps
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-----------------------------------------
// in       | input     | i_in_valid / o_in_stall | i_arrival_time
// out      | output    | o_out_valid/ i_out_stall| o_keep, o_presentation_time,
//          |           |                         | o_average_interval, o_*_count
// cfg      | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// one frame passes from input beat to output beat through the multiply, add, divide and
// decide steps, the divide done by the bit-serial divider forming the target index
// a new input beat is taken only in idle; the result sits in an output register, so
// the next frame can enter while the previous result is still stalled
// a finished frame waits in the decide step while an older result is still stalled
// synchronous active-low reset; no clearing pass
`include "frame_rate_decimator_assert.svh"
module frame_rate_decimator
    import frd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // frame timestamps
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [TIME_BITS-1:0]      i_arrival_time,
    // decisions
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_keep,
    output logic [TIME_BITS-1:0]      o_presentation_time,
    output logic [TIME_BITS-1:0]      o_average_interval,
    output logic [COUNT_BITS-1:0]     o_dropped_count,
    output logic [COUNT_BITS-1:0]     o_accepted_count,
    output logic [COUNT_BITS-1:0]     o_slow_count,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_ADD    = 5'b00100,
        S_DIV    = 5'b01000,
        S_DECIDE = 5'b10000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [CFG_BITS-1:0] r_rate_divisor;
    logic [CFG_BITS-1:0] r_period_limit;

    // decimator state
    logic                   r_first_pending, n_first_pending;
    logic [TIME_BITS-1:0]   r_previous_time, n_previous_time;
    logic [TIME_BITS-1:0]   r_origin_time,   n_origin_time;
    logic [TIME_BITS-1:0]   r_interval_avg,  n_interval_avg;
    logic [COUNT_BITS-1:0]  r_frame_number,  n_frame_number;
    logic [INDEX_BITS-1:0]  r_last_index,    n_last_index;
    logic [INDEX_BITS-1:0]  r_target_index,  n_target_index;
    logic [COUNT_BITS-1:0]  r_drop_total,    n_drop_total;
    logic [COUNT_BITS-1:0]  r_keep_total,    n_keep_total;
    logic [COUNT_BITS-1:0]  r_slow_total,    n_slow_total;
    logic                   n_keep;

    // working registers for one frame
    logic [TIME_BITS-1:0]            r_now;
    logic [COUNT_BITS+CFG_BITS-1:0]  r_prod;
    logic [INDEX_BITS-1:0]           r_quot;

    // output beat register
    logic                   r_o_valid;
    logic                   r_o_keep;
    logic [TIME_BITS-1:0]   r_o_pts;

    logic [CFG_BITS-1:0]    w_divisor;
    logic [TIME_BITS-1:0]   w_diff;
    logic [INDEX_BITS:0]    w_gap;
    logic                   w_in_beat;
    logic                   w_out_free;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;

    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_o_valid || !i_out_stall;

    // a zero divisor counts as one
    assign w_divisor = (r_rate_divisor == '0) ? CFG_BITS'(1) : r_rate_divisor;

    // rounded divide request: product plus half the divisor
    assign w_div_req.start     = (r_state == S_ADD);
    assign w_div_req.numerator = NUM_BITS'(r_prod) + NUM_BITS'(w_divisor >> 1);
    assign w_div_req.divisor   = w_divisor;

    frd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (w_in_beat) r_state <= S_MUL;
                S_MUL:    r_state <= S_ADD;
                S_ADD:    r_state <= S_DIV;
                S_DIV:    if (w_div_rsp.done) r_state <= S_DECIDE;
                S_DECIDE: if (w_out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) r_now <= i_arrival_time;
        if (r_state == S_MUL) r_prod <= (COUNT_BITS+CFG_BITS)'(r_frame_number)
                                      * (COUNT_BITS+CFG_BITS)'(INDEX_SCALE);
        if (r_state == S_DIV && w_div_rsp.done) begin
            // clamp to the largest positive index
            if (|w_div_rsp.quotient[NUM_BITS-1:INDEX_BITS-1]) r_quot <= INDEX_MAX;
            else r_quot <= w_div_rsp.quotient[INDEX_BITS-1:0];
        end
    end

    // keep / drop decision for the frame in hand
    always_comb begin
        n_first_pending = r_first_pending;
        n_previous_time = r_now;
        n_origin_time   = r_origin_time;
        n_interval_avg  = r_interval_avg;
        n_frame_number  = r_frame_number;
        n_last_index    = r_last_index;
        n_target_index  = r_target_index;
        n_drop_total    = r_drop_total;
        n_keep_total    = r_keep_total;
        n_slow_total    = r_slow_total;
        n_keep          = 1'b1;
        w_diff          = r_now - r_previous_time;
        w_gap           = '0;
        if (r_first_pending) begin
            n_first_pending = 1'b0;
            n_origin_time   = r_now;
            n_interval_avg  = TIME_BITS'(r_period_limit);
        end else begin
            // floor((avg + diff) / 2) without a carry out
            n_interval_avg = (r_interval_avg >> 1) + (w_diff >> 1)
                           + TIME_BITS'(r_interval_avg[0] & w_diff[0]);
            if (w_diff > TIME_BITS'(r_period_limit)) begin
                n_slow_total = sat_inc(r_slow_total);
            end else begin
                n_target_index = r_quot;
                w_gap = {1'b0, r_quot} - {r_last_index[INDEX_BITS-1], r_last_index};
                // drop while the last index trails by two to nine
                if (w_gap > (INDEX_BITS+1)'(1) && w_gap < INDEX_WINDOW) begin
                    n_keep       = 1'b0;
                    n_last_index = r_last_index + INDEX_BITS'(1);
                    n_drop_total = sat_inc(r_drop_total);
                end
            end
        end
        if (n_keep) begin
            n_keep_total   = sat_inc(r_keep_total);
            n_last_index   = n_target_index;
            n_frame_number = sat_inc(r_frame_number);
        end
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_divisor  <= DIVISOR_RESET;
            r_period_limit  <= PERIOD_RESET;
            r_first_pending <= 1'b1;
            r_previous_time <= '0;
            r_origin_time   <= '0;
            r_interval_avg  <= '0;
            r_frame_number  <= COUNT_BITS'(1);
            r_last_index    <= '1;
            r_target_index  <= '0;
            r_drop_total    <= '0;
            r_keep_total    <= '0;
            r_slow_total    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RATE_DIVISOR: r_rate_divisor <= i_cfg_data;
                    REG_PERIOD_LIMIT: r_period_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DECIDE && w_out_free) begin
                r_first_pending <= n_first_pending;
                r_previous_time <= n_previous_time;
                r_origin_time   <= n_origin_time;
                r_interval_avg  <= n_interval_avg;
                r_frame_number  <= n_frame_number;
                r_last_index    <= n_last_index;
                r_target_index  <= n_target_index;
                r_drop_total    <= n_drop_total;
                r_keep_total    <= n_keep_total;
                r_slow_total    <= n_slow_total;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DECIDE && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && w_out_free) begin
            r_o_keep <= n_keep;
            r_o_pts  <= r_now - n_origin_time;
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_keep              = r_o_keep;
    assign o_presentation_time = r_o_pts;
    assign o_average_interval  = r_interval_avg;
    assign o_dropped_count     = r_drop_total;
    assign o_accepted_count    = r_keep_total;
    assign o_slow_count        = r_slow_total;

    `FRD_ASSERT_NOW(a_drop_not_first, i_clk, i_rst_n, o_out_valid && !o_keep, !r_first_pending)
    `FRD_ASSERT_NOW(a_last_floor, i_clk, i_rst_n, r_last_index[INDEX_BITS-1],
        r_last_index == {INDEX_BITS{1'b1}})
    `FRD_ASSERT_NEXT(a_div_to_decide, i_clk, i_rst_n, r_state == S_DIV && w_div_rsp.done,
        r_state == S_DECIDE)

endmodule

>>> test/tb_frame_rate_decimator.sv
`timescale 1ns / 1ps
module tb_frame_rate_decimator;
    import frd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    // divider pass plus decide step, rounded up
    localparam int FRAME_LATENCY = 64;
    // cycles with no beat on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_OFF      = 400;

    // index arithmetic of the decimation rule
    localparam longint unsigned TICKS_PER_INDEX = 64'd10000000;
    localparam longint          INDEX_SPAN      = 64'sd10;
    localparam longint          INDEX_CEIL      = 64'sd8589934591;

    typedef struct packed {
        logic                  keep;
        logic [TIME_BITS-1:0]  pts;
        logic [TIME_BITS-1:0]  avg;
        logic [COUNT_BITS-1:0] dropped;
        logic [COUNT_BITS-1:0] kept;
        logic [COUNT_BITS-1:0] slow;
    } frame_verdict_t;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [TIME_BITS-1:0]      i_arrival_time = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic                      o_keep;
    logic [TIME_BITS-1:0]      o_presentation_time;
    logic [TIME_BITS-1:0]      o_average_interval;
    logic [COUNT_BITS-1:0]     o_dropped_count;
    logic [COUNT_BITS-1:0]     o_accepted_count;
    logic [COUNT_BITS-1:0]     o_slow_count;
    logic                      i_cfg_we       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index    = '0;
    logic [CFG_BITS-1:0]       i_cfg_data     = '0;

    frame_rate_decimator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_arrival_time      (i_arrival_time),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_keep              (o_keep),
        .o_presentation_time (o_presentation_time),
        .o_average_interval  (o_average_interval),
        .o_dropped_count     (o_dropped_count),
        .o_accepted_count    (o_accepted_count),
        .o_slow_count        (o_slow_count),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // decimator shadow: registers and frame state as the block should hold them
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]   divisor_reg    = CFG_BITS'(10000000);
    logic [CFG_BITS-1:0]   period_reg     = CFG_BITS'(333333);
    bit                    first_due      = 1'b1;
    logic [TIME_BITS-1:0]  prev_arrival   = '0;
    logic [TIME_BITS-1:0]  origin_arrival = '0;
    logic [TIME_BITS-1:0]  interval_avg   = '0;
    logic [COUNT_BITS-1:0] frame_seq      = COUNT_BITS'(1);
    longint                last_idx       = -64'sd1;
    longint                target_idx     = 64'sd0;
    logic [COUNT_BITS-1:0] drop_tally     = '0;
    logic [COUNT_BITS-1:0] keep_tally     = '0;
    logic [COUNT_BITS-1:0] slow_tally     = '0;

    frame_verdict_t pending_verdicts[$];
    int             mismatches    = 0;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             hold_cycles   = 0;
    int             quiet_cycles  = 0;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // rounded n * 10^7 / divisor, a zero divisor counting as one, clipped to 2^33-1
    function automatic longint target_for(input logic [COUNT_BITS-1:0] seq);
        longint unsigned d;
        longint unsigned q;
        d = (divisor_reg == '0) ? 64'd1 : 64'(divisor_reg);
        q = (64'(seq) * TICKS_PER_INDEX + (d >> 1)) / d;
        return (q > INDEX_CEIL) ? INDEX_CEIL : longint'(q);
    endfunction

    function automatic frame_verdict_t decide_frame(input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] gap;
        frame_verdict_t       v;
        v.keep = 1'b1;
        if (first_due) begin
            // first frame sets the time origin and seeds the average
            origin_arrival = now;
            prev_arrival   = now;
            interval_avg   = TIME_BITS'(period_reg);
            first_due      = 1'b0;
        end else begin
            gap          = now - prev_arrival;
            prev_arrival = now;
            // floor of (avg + gap) / 2 without a carry out
            interval_avg = (interval_avg >> 1) + (gap >> 1)
                         + TIME_BITS'(interval_avg[0] & gap[0]);
            if (gap > TIME_BITS'(period_reg)) begin
                // slow frame: kept, target index left alone
                slow_tally = bump(slow_tally);
            end else begin
                target_idx = target_for(frame_seq);
                if (last_idx < target_idx - 1 && target_idx - last_idx < INDEX_SPAN) begin
                    last_idx   = last_idx + 1;
                    drop_tally = bump(drop_tally);
                    v.keep     = 1'b0;
                end
            end
        end
        v.pts = now - origin_arrival;
        if (v.keep) begin
            keep_tally = bump(keep_tally);
            last_idx   = target_idx;
            frame_seq  = bump(frame_seq);
        end
        v.avg     = interval_avg;
        v.dropped = drop_tally;
        v.kept    = keep_tally;
        v.slow    = slow_tally;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // result checking, one beat at a time against the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        frame_verdict_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unrequested result", 64'd0, 64'(o_presentation_time));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_keep !== want.keep)
                    report_mismatch("keep", 64'(want.keep), 64'(o_keep));
                if (o_presentation_time !== want.pts)
                    report_mismatch("presentation_time", 64'(want.pts),
                                    64'(o_presentation_time));
                if (o_average_interval !== want.avg)
                    report_mismatch("average_interval", 64'(want.avg),
                                    64'(o_average_interval));
                if (o_dropped_count !== want.dropped)
                    report_mismatch("dropped_count", 64'(want.dropped),
                                    64'(o_dropped_count));
                if (o_accepted_count !== want.kept)
                    report_mismatch("accepted_count", 64'(want.kept),
                                    64'(o_accepted_count));
                if (o_slow_count !== want.slow)
                    report_mismatch("slow_count", 64'(want.slow), 64'(o_slow_count));
            end
        end
    end

    // receiver: a long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("[frame_rate_decimator] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers; all of them start and end on a falling edge
    // ------------------------------------------------------------------

    // valid stays high on return so back-to-back frames need no gap
    task automatic send_frame(input logic [TIME_BITS-1:0] stamp);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_arrival_time <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        pending_verdicts.push_back(decide_frame(stamp));
        @(negedge i_clk);
    endtask

    // drop valid, wait for every result, then let the pipeline go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (FRAME_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_RATE_DIVISOR)
            divisor_reg = data;
        else if (idx == REG_PERIOD_LIMIT)
            period_reg = data;
        @(negedge i_clk);
    endtask

    // mostly a steady camera with jitter, some late frames, a little noise
    function automatic logic [TIME_BITS-1:0] next_arrival(input logic [TIME_BITS-1:0] prior);
        int          pick;
        int unsigned lim;
        pick = $urandom_range(99);
        lim  = 32'(period_reg);
        if (pick < 8)
            return TIME_BITS'({$urandom, $urandom});
        if (pick < 18)
            return prior + TIME_BITS'(64'(lim) + $urandom_range(1, 2 * lim + 1));
        if (pick < 22)
            return prior + (pick[0] ? TIME_BITS'(lim) : TIME_BITS'(0));
        return prior + TIME_BITS'($urandom_range(lim >> 1, lim));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: first frame at the top of the time range, wrap, boundaries
    task automatic test_first_frame_and_wrap();
        logic [TIME_BITS-1:0] stamp;
        stamp = '1;
        send_frame(stamp);
        stamp = '0;                                  // wraps, interval of one
        send_frame(stamp);
        stamp = stamp + TIME_BITS'(period_reg);      // exactly at the limit
        send_frame(stamp);
        stamp = stamp + TIME_BITS'(period_reg) + 1'b1;   // just over: slow
        send_frame(stamp);
        send_frame(stamp);                           // zero interval
        repeat (3) begin
            stamp = stamp + TIME_BITS'(100000);
            send_frame(stamp);
        end
        stamp = stamp ^ {1'b1, {(TIME_BITS-1){1'b0}}};   // huge jump
        send_frame(stamp);
        stamp = stamp + 1'b1;
        send_frame(stamp);
    endtask

    // register extremes, a zero divisor and a zero period limit among them
    task automatic test_config_extremes();
        logic [TIME_BITS-1:0] stamp;
        settle();
        write_reg(REG_RATE_DIVISOR, '0);
        write_reg(REG_PERIOD_LIMIT, '1);
        stamp = prev_arrival;
        repeat (4) begin
            stamp = stamp + TIME_BITS'(1000);
            send_frame(stamp);
        end
        settle();
        write_reg(REG_RATE_DIVISOR, '1);
        write_reg(REG_PERIOD_LIMIT, CFG_BITS'(1));
        send_frame(stamp);
        send_frame(stamp + TIME_BITS'(1));
        send_frame(stamp + TIME_BITS'(3));
        send_frame(stamp + TIME_BITS'(4));
        settle();
        write_reg(REG_RATE_DIVISOR, CFG_BITS'(1));
        write_reg(REG_PERIOD_LIMIT, '0);
        stamp = prev_arrival;
        send_frame(stamp);
        send_frame(stamp + TIME_BITS'(5));
        send_frame(stamp + TIME_BITS'(5));
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        logic [TIME_BITS-1:0] stamp;
        settle();
        write_reg(REG_RATE_DIVISOR, CFG_BITS'(5000000));
        write_reg(REG_PERIOD_LIMIT, CFG_BITS'(333333));
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = HOLD_OFF;
        stamp = prev_arrival;
        repeat (10) begin
            stamp = stamp + TIME_BITS'($urandom_range(150000, 333333));
            send_frame(stamp);
        end
    endtask

    // random frame stream under one register setting and one idling pattern
    task automatic test_random_stream(input int idle_pct, input int busy_pct,
                                      input int frames, input logic [CFG_BITS-1:0] divisor,
                                      input logic [CFG_BITS-1:0] limit);
        logic [TIME_BITS-1:0] stamp;
        settle();
        write_reg(REG_RATE_DIVISOR, divisor);
        write_reg(REG_PERIOD_LIMIT, limit);
        stamp = prev_arrival;
        for (int n = 0; n < frames; n++) begin
            // a stretch without idling at the start of every fifty frames
            if (n % 50 < 12) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end else begin
                send_idle_pct = idle_pct;
                stall_pct     = busy_pct;
            end
            stamp = next_arrival(stamp);
            send_frame(stamp);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_frame_and_wrap();
        test_config_extremes();
        test_output_backpressure();

        // halving, thirds, pass-through and random ratios under each idling pattern
        test_random_stream(0, 0, 200, CFG_BITS'(5000000), CFG_BITS'(333333));
        test_random_stream(76, 0, 200, CFG_BITS'(3333333), CFG_BITS'(400000));
        test_random_stream(0, 76, 200, CFG_BITS'($urandom_range(1000000, 16777215)),
                           CFG_BITS'($urandom_range(1000, 2000000)));
        test_random_stream(7, 7, 200, '1, CFG_BITS'(100000));
        test_random_stream(0, 0, 200, CFG_BITS'(7500000), CFG_BITS'(1000000));
        test_random_stream(76, 0, 150, CFG_BITS'(2000000), CFG_BITS'(50000));
        test_random_stream(0, 76, 150, CFG_BITS'(10000000), CFG_BITS'(333333));
        // unit divisor late in the run drives the target index into its ceiling
        test_random_stream(7, 7, 300, CFG_BITS'(1), CFG_BITS'(333333));

        settle();
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("[frame_rate_decimator] OK");
        end else begin
            $display("[frame_rate_decimator] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/frd_pkg.sv
hw/rtl/frd_div.sv
hw/rtl/frame_rate_decimator.sv
test/tb_frame_rate_decimator.sv
